### hw/rtl/xfd_pkg.sv
// Shared types and constants for the XOR frame decoder.
package xfd_pkg;

    localparam int MAX_PAYLOAD_DEF = 60;
    localparam int BYTE_W          = 8;
    localparam int FUNC_W          = 16;
    localparam int IDX_W           = 6;
    localparam int POS_W           = 9;
    localparam int HDR_LEN         = 3;   // func hi, func lo, length

    typedef enum logic [1:0] {
        STAT_GOOD  = 2'd0,
        STAT_CKSUM = 2'd1,
        STAT_LEN   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_RX,
        ST_RD,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic take;         // input beat accepted
        logic emit_single;  // checksum beat yields one summary result
        logic start_drain;  // good frame with payload: clear drain index
        logic rd_en;        // read payload store at drain index
        logic emit_byte;    // load output with read data
    } t_dp_cmd;

    typedef struct packed {
        logic is_ck;        // current position is the checksum byte
        logic drain_req;    // checksum beat would start a payload drain
        logic out_free;     // output register can take a result this cycle
        logic idx_last;     // drain index is the final payload byte
    } t_dp_status;

endpackage

### hw/rtl/xfd_ctrl.sv
// Control state machine: byte intake and payload drain sequencing.
module xfd_ctrl
    import xfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output logic       o_in_stall,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   ck_blocked;
    logic   take;

    assign ck_blocked = i_status.is_ck && !i_status.out_free;
    assign take       = (r_state == ST_RX) && i_in_valid && !ck_blocked;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RX;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_RX: begin
                if (take && i_status.is_ck && i_status.drain_req) begin
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    n_state = i_status.idx_last ? ST_RX : ST_RD;
                end
            end
            default: begin
                n_state = ST_RX;
            end
        endcase
    end

    always_comb begin
        o_in_stall        = (r_state != ST_RX) || ck_blocked;
        o_cmd.take        = take;
        o_cmd.emit_single = take && i_status.is_ck && !i_status.drain_req;
        o_cmd.start_drain = take && i_status.is_ck && i_status.drain_req;
        o_cmd.rd_en       = (r_state == ST_RD);
        o_cmd.emit_byte   = (r_state == ST_EMIT) && i_status.out_free;
    end

endmodule

### hw/rtl/xfd_datapath.sv
// Frame registers, running XOR, payload store and output register.
module xfd_datapath
    import xfd_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_status,
    input  logic [BYTE_W-1:0] i_rx_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [1:0]        o_status_code,
    output logic [FUNC_W-1:0] o_function_code,
    output logic [BYTE_W-1:0] o_payload_length,
    output logic [IDX_W-1:0]  o_byte_index,
    output logic [BYTE_W-1:0] o_payload_byte,
    output logic              o_has_byte,
    output logic              o_last
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  n_pos;
    logic [FUNC_W-1:0] r_func;
    logic [BYTE_W-1:0] r_len;
    logic [BYTE_W-1:0] r_xor;
    logic [IDX_W-1:0]  r_idx;
    logic [BYTE_W-1:0] r_rd_data;
    logic [BYTE_W-1:0] r_mem [MAX_PAYLOAD];

    logic              r_out_valid;
    t_status           r_out_status;
    logic [FUNC_W-1:0] r_out_func;
    logic [BYTE_W-1:0] r_out_len;
    logic [IDX_W-1:0]  r_out_idx;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_has;
    logic              r_out_last;

    logic [POS_W-1:0]  pos_idx;
    logic [POS_W-1:0]  payload_end;
    logic              past_hdr;
    logic              is_payload;
    logic              is_ck;
    logic              too_long;
    logic              xor_bad;
    logic              out_free;
    logic              idx_last;
    t_status           single_code;

    assign pos_idx     = r_pos - POS_W'(HDR_LEN);
    assign payload_end = {1'b0, r_len} + POS_W'(HDR_LEN);
    assign past_hdr    = (r_pos >= POS_W'(HDR_LEN));
    assign is_payload  = past_hdr && (r_pos < payload_end);
    assign is_ck       = past_hdr && !is_payload;
    assign too_long    = ({1'b0, r_len} > POS_W'(MAX_PAYLOAD));
    assign xor_bad     = (r_xor != i_rx_byte);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign idx_last    = ((BYTE_W'(r_idx) + BYTE_W'(1)) == r_len);

    assign o_status.is_ck     = is_ck;
    assign o_status.drain_req = !too_long && !xor_bad && (r_len != '0);
    assign o_status.out_free  = out_free;
    assign o_status.idx_last  = idx_last;

    always_comb begin
        if (too_long) begin
            single_code = STAT_LEN;
        end else if (xor_bad) begin
            single_code = STAT_CKSUM;
        end else begin
            single_code = STAT_GOOD;
        end
    end

    always_comb begin
        n_pos = r_pos;
        case (r_pos)
            POS_W'(0): n_pos = POS_W'(1);
            POS_W'(1): n_pos = POS_W'(2);
            POS_W'(2): n_pos = POS_W'(3);
            default: begin
                n_pos = is_payload ? r_pos + POS_W'(1) : '0;
            end
        endcase
    end

    // frame collection
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_func <= '0;
            r_len  <= '0;
            r_xor  <= '0;
        end else if (i_cmd.take) begin
            r_pos <= n_pos;
            case (r_pos)
                POS_W'(0): begin
                    r_func[FUNC_W-1:BYTE_W] <= i_rx_byte;
                    r_xor                   <= i_rx_byte;
                end
                POS_W'(1): begin
                    r_func[BYTE_W-1:0] <= i_rx_byte;
                    r_xor              <= r_xor ^ i_rx_byte;
                end
                POS_W'(2): begin
                    r_len <= i_rx_byte;
                    r_xor <= r_xor ^ i_rx_byte;
                end
                default: begin
                    if (is_payload) begin
                        r_xor <= r_xor ^ i_rx_byte;
                    end
                end
            endcase
        end
    end

    // payload store, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && is_payload && (pos_idx < POS_W'(MAX_PAYLOAD))) begin
            r_mem[pos_idx[AW-1:0]] <= i_rx_byte;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.start_drain) begin
            r_idx <= '0;
        end else if (i_cmd.emit_byte) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_single || i_cmd.emit_byte) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_single) begin
            r_out_status <= single_code;
            r_out_func   <= r_func;
            r_out_len    <= r_len;
            r_out_idx    <= '0;
            r_out_byte   <= '0;
            r_out_has    <= 1'b0;
            r_out_last   <= 1'b1;
        end else if (i_cmd.emit_byte) begin
            r_out_status <= STAT_GOOD;
            r_out_func   <= r_func;
            r_out_len    <= r_len;
            r_out_idx    <= r_idx;
            r_out_byte   <= r_rd_data;
            r_out_has    <= 1'b1;
            r_out_last   <= idx_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status_code    = r_out_status;
    assign o_function_code  = r_out_func;
    assign o_payload_length = r_out_len;
    assign o_byte_index     = r_out_idx;
    assign o_payload_byte   = r_out_byte;
    assign o_has_byte       = r_out_has;
    assign o_last           = r_out_last;

endmodule

### hw/rtl/xor_frame_decoder.sv
// Top level of the XOR-checksum frame decoder.
// Takes one received byte per beat; a frame is function high byte, function low byte,
// length, payload, checksum (XOR of all preceding frame bytes). Header and payload beats
// are taken one per cycle while no payload drain runs, and give no result. The checksum beat
// gives one result (status good with no payload, checksum mismatch, or length over
// MAX_PAYLOAD) or, for a good frame, starts a drain of the stored payload: each payload byte
// is read from the store, then loaded into the output register when it is free; input is held
// off until the last payload byte is loaded. Results sit in an output register; a non-checksum
// byte is taken even while a result waits there, a checksum byte waits until that register is free.
module xor_frame_decoder
    import xfd_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [BYTE_W-1:0] i_rx_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [1:0]        o_status,
    output logic [FUNC_W-1:0] o_function_code,
    output logic [BYTE_W-1:0] o_payload_length,
    output logic [IDX_W-1:0]  o_byte_index,
    output logic [BYTE_W-1:0] o_payload_byte,
    output logic              o_has_byte,
    output logic              o_last
);

    t_dp_cmd    cmd;
    t_dp_status dp_status;

    xfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (dp_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    xfd_datapath #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (dp_status),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status_code    (o_status),
        .o_function_code  (o_function_code),
        .o_payload_length (o_payload_length),
        .o_byte_index     (o_byte_index),
        .o_payload_byte   (o_payload_byte),
        .o_has_byte       (o_has_byte),
        .o_last           (o_last)
    );

endmodule
